>>> design/gne_pkg.sv
package gne_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned MaxRadiusDef = 7;

  localparam logic [14:0] CostCardinal = 15'd16384;
  localparam logic [14:0] CostDiagonal = 15'd23170;

  typedef enum logic [1:0] {
    FuncWrite   = 2'd0,
    FuncNeighbr = 2'd1,
    FuncDensity = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegDiag   = 2'd2,
    RegRadius = 2'd3
  } reg_e;

  // neighbour read slots: centre-relative offsets
  // 0:+x 1:-x 2:+y 3:-y 4:(+1,+1) 5:(+1,-1) 6:(-1,+1) 7:(-1,-1)
  function automatic logic signed [1:0] slot_dx(input logic [2:0] s);
    case (s)
      3'd0, 3'd4, 3'd5: slot_dx = 2'sd1;
      3'd1, 3'd6, 3'd7: slot_dx = -2'sd1;
      default:          slot_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] slot_dy(input logic [2:0] s);
    case (s)
      3'd2, 3'd4, 3'd6: slot_dy = 2'sd1;
      3'd3, 3'd5, 3'd7: slot_dy = -2'sd1;
      default:          slot_dy = 2'sd0;
    endcase
  endfunction

endpackage

>>> design/gne_ram.sv
module gne_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/grid_neighbor_expander_unit.sv
// channel | dir | handshake        | payload
// s_axis  | in  | tvalid/tready    | tdata {occupied,cell_y,cell_x,func}
// m_axis  | out | tvalid/tready    | tdata, tlast
// apb     | cfg | psel/penable     | grid_width, grid_height, diagonal_moves, window_radius
// from one input transfer to the next: a write is one pass through StWrite; a neighbour query
// makes eight slot reads (with a bubble before the last) and then emits its results one by
// one; a density query reads every cell of the window through the single memory read port.
// after reset a clearing pass over all 2**(Xw+Yw) cells (65536 at the default size) sets
// every cell blocked; no input is taken until it is done.
// results wait in an output register; the engine stalls while it is full and not taken.
module grid_neighbor_expander_unit #(
  parameter int unsigned MAX_WIDTH  = gne_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = gne_pkg::MaxHeightDef,
  parameter int unsigned MAX_RADIUS = gne_pkg::MaxRadiusDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] func, [9:2] cell_x, [17:10] cell_y, [18] occupied
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] neighbor_found, [8:1] neighbor_x, [16:9] neighbor_y, [31:17] step_cost,
  // [39:32] obstacle_count, [47:40] window_count
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import gne_pkg::*;

  localparam int unsigned Xw    = $clog2(MAX_WIDTH);
  localparam int unsigned Yw    = $clog2(MAX_HEIGHT);
  localparam int unsigned Aw    = Xw + Yw;
  localparam int unsigned Depth = 1 << Aw;
  localparam int unsigned Cw    = 14; // signed coord, covers up to 4096 + radius
  localparam int unsigned Rw    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned Dw    = Rw + 2; // window offset width
  localparam int unsigned Nw    = 2 * Rw + 3; // window count width

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StNRead = 7'b0000100,
    StNEmit = 7'b0001000,
    StDRead = 7'b0010000,
    StDOut  = 7'b0100000,
    StWrite = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [8:0] width_q, height_q;
  logic       diag_q;
  logic [2:0] radius_q;
  logic       cfg_we;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      diag_q   <= 1'b0;
      radius_q <= 3'd1;
    end else if (cfg_we) begin
      case (paddr_i[3:2])
        RegWidth:  width_q  <= pwdata_i[8:0];
        RegHeight: height_q <= pwdata_i[8:0];
        RegDiag:   diag_q   <= pwdata_i[0];
        RegRadius: radius_q <= pwdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    case (paddr_i[3:2])
      RegWidth:  prdata_o[8:0] = width_q;
      RegHeight: prdata_o[8:0] = height_q;
      RegDiag:   prdata_o[0]   = diag_q;
      RegRadius: prdata_o[2:0] = radius_q;
      default: ;
    endcase
  end

  logic [Cw-1:0] eff_w, eff_h;
  logic [Rw-1:0] eff_r;
  always_comb begin
    if (width_q == 9'd0) eff_w = Cw'(1);
    else if (32'(width_q) > MAX_WIDTH) eff_w = Cw'(MAX_WIDTH);
    else eff_w = Cw'(width_q);
    if (height_q == 9'd0) eff_h = Cw'(1);
    else if (32'(height_q) > MAX_HEIGHT) eff_h = Cw'(MAX_HEIGHT);
    else eff_h = Cw'(height_q);
    if (32'(radius_q) > MAX_RADIUS) eff_r = Rw'(MAX_RADIUS);
    else eff_r = Rw'(radius_q);
  end

  // item registers
  logic [7:0]    cx_q, cy_q;
  logic          occ_q;
  logic          in_fire;
  logic [Aw-1:0] clr_q, clr_d;

  // centre-inside flag for neighbour queries
  logic pin_c_q;
  logic cin;

  // read sequencing: issue address, see the registered data in the next cycle
  logic [2:0]           slot_q, slot_d;       // neighbour slot being issued
  logic                 rvalid_q, rvalid_d;   // a read is in flight
  logic [2:0]           rslot_q, rslot_d;
  logic                 rin_q, rin_d;         // in-flight cell lies inside
  logic [7:0]           freem_q, freem_d;     // free mask per slot
  logic signed [Rw+1:0] dx_q, dx_d, dy_q, dy_d;
  logic                 dlast_q, dlast_d;     // last window read issued
  logic [Nw-1:0]        obs_q, obs_d;

  logic               ram_we;
  logic [Aw-1:0]      ram_wa, ram_ra;
  logic               ram_wd, ram_rd;

  gne_ram #(.Width(1), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  // output register
  logic        ovalid_q, ovalid_d;
  logic [47:0] odata_q, odata_d;
  logic        olast_q, olast_d;
  logic        ofree;
  assign ofree           = !ovalid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  assign cin = (Cw'(s_axis_tdata_i[9:2]) < eff_w) && (Cw'(s_axis_tdata_i[17:10]) < eff_h);

  // address generation for the current probe; a write uses the item cell itself
  logic signed [Cw-1:0] px, py;
  logic                 pin;
  always_comb begin
    if (state_q == StDRead) begin
      px = $signed(Cw'(cx_q)) + Cw'(dx_q);
      py = $signed(Cw'(cy_q)) + Cw'(dy_q);
    end else if (state_q == StWrite) begin
      px = $signed(Cw'(cx_q));
      py = $signed(Cw'(cy_q));
    end else begin
      px = $signed(Cw'(cx_q)) + Cw'(slot_dx(slot_q));
      py = $signed(Cw'(cy_q)) + Cw'(slot_dy(slot_q));
    end
    pin = (px >= 0) && (py >= 0) && (px < $signed(eff_w)) && (py < $signed(eff_h));
  end

  // neighbour emit selection
  logic [7:0] emit_q, emit_d;
  logic [2:0] esel;
  logic       ehas, emore;
  always_comb begin
    esel = '0;
    ehas = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (emit_q[i]) begin
        esel = 3'(i);
        ehas = 1'b1;
      end
    end
    emore = |(emit_q & ~(8'b1 << esel));
  end

  logic [Nw-1:0] side;
  assign side = Nw'({eff_r, 1'b1});

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    slot_d   = slot_q;
    rvalid_d = 1'b0;
    rslot_d  = slot_q;
    rin_d    = pin;
    freem_d  = freem_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    dlast_d  = dlast_q;
    obs_d    = obs_q;
    emit_d   = emit_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odata_d  = odata_q;
    olast_d  = olast_q;
    ram_we   = 1'b0;
    ram_wa   = clr_q;
    ram_wd   = 1'b1;
    ram_ra   = {py[Yw-1:0], px[Xw-1:0]};

    // fold in returned read data
    if (rvalid_q) begin
      if (state_q == StDRead || state_q == StDOut) begin
        if (!(rin_q && !ram_rd)) obs_d = obs_q + Nw'(1);
      end else begin
        freem_d[rslot_q] = rin_q & !ram_rd;
      end
    end

    case (state_q)
      StClear: begin
        ram_we = 1'b1;
        clr_d  = clr_q + Aw'(1);
        if (clr_q == Aw'(Depth - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_fire) begin
          slot_d = '0;
          case (func_e'(s_axis_tdata_i[1:0]))
            FuncWrite:   state_d = StWrite;
            FuncNeighbr: begin
              state_d = StNRead;
              freem_d = '0;
            end
            FuncDensity: begin
              state_d = StDRead;
              obs_d   = '0;
              dx_d    = -$signed({2'b00, eff_r});
              dy_d    = -$signed({2'b00, eff_r});
              dlast_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      StWrite: begin
        ram_we  = pin;
        ram_wa  = {py[Yw-1:0], px[Xw-1:0]};
        ram_wd  = occ_q;
        state_d = StIdle;
      end
      StNRead: begin
        if (!(slot_q == 3'd7 && rvalid_q)) begin
          rvalid_d = !(slot_q == 3'd7 && rslot_q == 3'd7 && rvalid_q);
          slot_d   = (slot_q == 3'd7) ? slot_q : slot_q + 3'd1;
        end
        if (rvalid_q && rslot_q == 3'd7) begin
          rvalid_d = 1'b0;
          state_d  = StNEmit;
          // centre outside: no neighbours at all
          emit_d   = '0;
        end
      end
      StNEmit: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          odata_d  = '0;
          if (ehas) begin
            odata_d[0]     = 1'b1;
            odata_d[8:1]   = 8'(cx_q + 8'(slot_dx(esel)));
            odata_d[16:9]  = 8'(cy_q + 8'(slot_dy(esel)));
            odata_d[31:17] = esel[2] ? CostDiagonal : CostCardinal;
          end
          olast_d = !emore;
          emit_d  = emit_q & ~(8'b1 << esel);
          if (!emore) state_d = StIdle;
        end
      end
      StDRead: begin
        if (!dlast_q) begin
          rvalid_d = 1'b1;
          if (dx_q == $signed({2'b00, eff_r})) begin
            dx_d = -$signed({2'b00, eff_r});
            dy_d = dy_q + Dw'(1);
            if (dy_q == $signed({2'b00, eff_r})) dlast_d = 1'b1;
          end else begin
            dx_d = dx_q + Dw'(1);
          end
          if (dx_q == $signed({2'b00, eff_r}) && dy_q == $signed({2'b00, eff_r}))
            state_d = StDOut;
        end
      end
      StDOut: begin
        if (!rvalid_q && ofree) begin
          ovalid_d        = 1'b1;
          odata_d         = '0;
          odata_d[39:32]  = 8'(obs_q);
          odata_d[47:40]  = 8'(side * side);
          olast_d         = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // load emit mask as soon as the last neighbour read lands
    if (state_q == StNRead && rvalid_q && rslot_q == 3'd7) begin
      emit_d = '0;
      if (pin_c_q) begin
        emit_d        = {4'b0000, freem_d[3:0]};
        if (diag_q) begin
          emit_d[4] = freem_d[4] & freem_d[0] & freem_d[2];
          emit_d[5] = freem_d[5] & freem_d[0] & freem_d[3];
          emit_d[6] = freem_d[6] & freem_d[1] & freem_d[2];
          emit_d[7] = freem_d[7] & freem_d[1] & freem_d[3];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rvalid_q <= rvalid_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cx_q    <= s_axis_tdata_i[9:2];
      cy_q    <= s_axis_tdata_i[17:10];
      occ_q   <= s_axis_tdata_i[18];
      pin_c_q <= cin;
    end
    slot_q  <= slot_d;
    rslot_q <= rslot_d;
    rin_q   <= rin_d;
    freem_q <= freem_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dlast_q <= dlast_d;
    obs_q   <= obs_d;
    emit_q  <= emit_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

endmodule

>>> design/gne_checker.sv
module gne_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        pready_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");
  a_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[47:32] == 16'd0)
    else $error("neighbour result carries counts");
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tlast_o)
    else $error("empty result not last");
endmodule

bind grid_neighbor_expander_unit gne_checker u_gne_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o),
  .pready_o(pready_o)
);
